@@ hw/rtl/rsa_ckd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_ckd_pkg
// Shared types and constants of the RSA CRT key derivation block.
// ----------------------------------------------------------------------------
package rsa_ckd_pkg;

  localparam int unsigned PRIME_WIDTH_DEF = 32;
  localparam int unsigned FIELD_W         = 32;
  localparam int unsigned WIDE_W          = 64;
  localparam logic [FIELD_W-1:0] PUB_EXP_RESET = 32'd65537;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_N,
    ST_PHI,
    ST_EUC_CHK,
    ST_DIV,
    ST_QM,
    ST_D,
    ST_DP,
    ST_DQ,
    ST_PWI,
    ST_PW_CHK,
    ST_AMUL,
    ST_AMOD,
    ST_BMUL,
    ST_BMOD,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_N,
    OP_PHI,
    OP_DIV,
    OP_QM,
    OP_D,
    OP_DP,
    OP_DQ,
    OP_PWI,
    OP_AMUL,
    OP_AMOD,
    OP_BMUL,
    OP_BMOD,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic start;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic unit_done;
    logic b_zero;
    logic ex_zero;
    logic ex_lsb;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/rsa_ckd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_ckd_if
// Valid/ready channels for prime pairs and derived keys.
// ----------------------------------------------------------------------------
interface rsa_ckd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_prime;
  logic [31:0] second_prime;

  modport source (output valid, output first_prime, output second_prime, input ready);
  modport sink   (input valid, input first_prime, input second_prime, output ready);
endinterface

interface rsa_ckd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] modulus;
  logic [63:0] decrypt_exponent;
  logic [31:0] exponent_p;
  logic [31:0] exponent_q;
  logic [31:0] crt_coefficient;

  modport source (output valid, output modulus, output decrypt_exponent, output exponent_p,
                  output exponent_q, output crt_coefficient, input ready);
  modport sink   (input valid, input modulus, input decrypt_exponent, input exponent_p,
                  input exponent_q, input crt_coefficient, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rsa_ckd_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_ckd_alu
// Bit-serial 64-bit multiplier (truncated product) and restoring divider,
// both running 64 steps from one start pulse.
// ----------------------------------------------------------------------------
module rsa_ckd_alu (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] mul_a_i,
  input  wire logic [63:0] mul_b_i,
  input  wire logic [63:0] div_num_i,
  input  wire logic [63:0] div_den_i,
  output logic      [63:0] prod_o,
  output logic      [63:0] quo_o,
  output logic      [63:0] rem_o,
  output logic             done_o
);
  import rsa_ckd_pkg::*;

  logic [WIDE_W-1:0] ma_q, mb_q, prod_q, quo_q, rem_q, den_q;
  logic [5:0]        cnt_q;
  logic              busy_q, done_q;
  logic [WIDE_W:0]   r_ext, r_sub;
  logic              ge;

  always_comb begin
    r_ext = {rem_q, quo_q[WIDE_W-1]};
    r_sub = r_ext - {1'b0, den_q};
    ge    = (r_ext >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q   <= mul_a_i;
      mb_q   <= mul_b_i;
      prod_q <= '0;
      quo_q  <= div_num_i;
      rem_q  <= '0;
      den_q  <= div_den_i;
    end else if (busy_q) begin
      prod_q <= prod_q + (mb_q[0] ? ma_q : '0);
      ma_q   <= {ma_q[WIDE_W-2:0], 1'b0};
      mb_q   <= {1'b0, mb_q[WIDE_W-1:1]};
      quo_q  <= {quo_q[WIDE_W-2:0], ge};
      rem_q  <= ge ? r_sub[WIDE_W-1:0] : r_ext[WIDE_W-1:0];
    end
  end

  assign prod_o = prod_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;
endmodule
`default_nettype wire

@@ hw/rtl/rsa_ckd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_ckd_ctrl
// Sequencer for modulus, Euclid loop, CRT exponents and modular power.
// ----------------------------------------------------------------------------
module rsa_ckd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rsa_ckd_pkg::sts_t sts_i,
  output rsa_ckd_pkg::cmd_t      cmd_o
);
  import rsa_ckd_pkg::*;

  state_e state_q, state_d;
  logic   issued_q, issued_d;
  logic   unit_st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_N;
      ST_N:       if (sts_i.unit_done) state_d = ST_PHI;
      ST_PHI:     if (sts_i.unit_done) state_d = ST_EUC_CHK;
      ST_EUC_CHK: state_d = sts_i.b_zero ? ST_D : ST_DIV;
      ST_DIV:     if (sts_i.unit_done) state_d = ST_QM;
      ST_QM:      if (sts_i.unit_done) state_d = ST_EUC_CHK;
      ST_D:       state_d = ST_DP;
      ST_DP:      if (sts_i.unit_done) state_d = ST_DQ;
      ST_DQ:      if (sts_i.unit_done) state_d = ST_PWI;
      ST_PWI:     if (sts_i.unit_done) state_d = ST_PW_CHK;
      ST_PW_CHK: begin
        if (sts_i.ex_zero)     state_d = ST_OUT;
        else if (sts_i.ex_lsb) state_d = ST_AMUL;
        else                   state_d = ST_BMUL;
      end
      ST_AMUL:    if (sts_i.unit_done) state_d = ST_AMOD;
      ST_AMOD:    if (sts_i.unit_done) state_d = ST_BMUL;
      ST_BMUL:    if (sts_i.unit_done) state_d = ST_BMOD;
      ST_BMOD:    if (sts_i.unit_done) state_d = ST_PW_CHK;
      ST_OUT:     if (!sts_i.out_busy) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '{op: OP_NONE, start: 1'b0, commit: 1'b0};
    in_ready_o = 1'b0;
    unit_st    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        unit_st      = 1'b0;
        in_ready_o   = 1'b1;
        cmd_o.op     = OP_LOAD;
        cmd_o.commit = in_valid_i;
      end
      ST_N:    cmd_o.op = OP_N;
      ST_PHI:  cmd_o.op = OP_PHI;
      ST_DIV:  cmd_o.op = OP_DIV;
      ST_QM:   cmd_o.op = OP_QM;
      ST_DP:   cmd_o.op = OP_DP;
      ST_DQ:   cmd_o.op = OP_DQ;
      ST_PWI:  cmd_o.op = OP_PWI;
      ST_AMUL: cmd_o.op = OP_AMUL;
      ST_AMOD: cmd_o.op = OP_AMOD;
      ST_BMUL: cmd_o.op = OP_BMUL;
      ST_BMOD: cmd_o.op = OP_BMOD;
      ST_D: begin
        unit_st      = 1'b0;
        cmd_o.op     = OP_D;
        cmd_o.commit = 1'b1;
      end
      ST_OUT: begin
        unit_st      = 1'b0;
        cmd_o.op     = OP_OUT;
        cmd_o.commit = !sts_i.out_busy;
      end
      default: unit_st = 1'b0;
    endcase
    if (unit_st) begin
      cmd_o.start  = !issued_q;
      cmd_o.commit = issued_q && sts_i.unit_done;
    end
  end

  always_comb begin
    issued_d = issued_q;
    if (cmd_o.start)  issued_d = 1'b1;
    if (cmd_o.commit) issued_d = 1'b0;
  end
endmodule
`default_nettype wire

@@ hw/rtl/rsa_ckd_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_ckd_datapath
// Working registers, operand selection for the shared serial unit, Bezout
// update and the output register.
// ----------------------------------------------------------------------------
module rsa_ckd_datapath #(
  parameter int unsigned PRIME_WIDTH = rsa_ckd_pkg::PRIME_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rsa_ckd_pkg::cmd_t cmd_i,
  output rsa_ckd_pkg::sts_t      sts_o,
  input  wire logic [31:0]       first_prime_i,
  input  wire logic [31:0]       second_prime_i,
  input  wire logic [31:0]       pub_exp_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [63:0]            modulus_o,
  output logic [63:0]            decrypt_exponent_o,
  output logic [31:0]            exponent_p_o,
  output logic [31:0]            exponent_q_o,
  output logic [31:0]            crt_coefficient_o
);
  import rsa_ckd_pkg::*;

  localparam logic [FIELD_W-1:0] MASK = FIELD_W'((64'd1 << PRIME_WIDTH) - 64'd1);

  logic [FIELD_W-1:0] p_q, q_q, pm1_q, qm1_q, pm2_q, dp_q, dq_q, acc_q, base_q, ex_q;
  logic [WIDE_W-1:0]  n_q, phi_q, a_q, b_q, m2_q, m1_q, quo_q, rem_q, d_q, t_q;
  logic               s2_q, s1_q;
  logic               out_valid_q;
  logic [WIDE_W-1:0]  o_n_q, o_d_q;
  logic [FIELD_W-1:0] o_dp_q, o_dq_q, o_crt_q;

  logic [WIDE_W-1:0]  mul_a, mul_b, div_n, div_d, prod, quo, rem;
  logic               done;
  logic [FIELD_W-1:0] p_in, q_in;
  logic [WIDE_W-1:0]  nm;
  logic               ns;

  rsa_ckd_alu u_alu (
    .clk_i,
    .rst_ni,
    .start_i   (cmd_i.start),
    .mul_a_i   (mul_a),
    .mul_b_i   (mul_b),
    .div_num_i (div_n),
    .div_den_i (div_d),
    .prod_o    (prod),
    .quo_o     (quo),
    .rem_o     (rem),
    .done_o    (done)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = '0;
    case (cmd_i.op)
      OP_N:    begin mul_a = WIDE_W'(p_q);    mul_b = WIDE_W'(q_q);    end
      OP_PHI:  begin mul_a = WIDE_W'(pm1_q);  mul_b = WIDE_W'(qm1_q);  end
      OP_DIV:  begin div_n = a_q;             div_d = b_q;             end
      OP_QM:   begin mul_a = quo_q;           mul_b = m1_q;            end
      OP_DP:   begin div_n = d_q;             div_d = WIDE_W'(pm1_q);  end
      OP_DQ:   begin div_n = d_q;             div_d = WIDE_W'(qm1_q);  end
      OP_PWI:  begin div_n = WIDE_W'(q_q);    div_d = WIDE_W'(p_q);    end
      OP_AMUL: begin mul_a = WIDE_W'(acc_q);  mul_b = WIDE_W'(base_q); end
      OP_BMUL: begin mul_a = WIDE_W'(base_q); mul_b = WIDE_W'(base_q); end
      OP_AMOD, OP_BMOD: begin div_n = t_q;   div_d = WIDE_W'(p_q);    end
      default: ;
    endcase
  end

  // x2 - quo*x1 on sign-magnitude coefficients
  always_comb begin
    ns = s2_q;
    if (prod == '0) begin
      nm = m2_q;
    end else if (s2_q != s1_q) begin
      nm = m2_q + prod;
    end else if (m2_q >= prod) begin
      nm = m2_q - prod;
    end else begin
      nm = prod - m2_q;
      ns = !s2_q;
    end
    if (nm == '0) ns = 1'b0;
  end

  assign p_in = first_prime_i & MASK;
  assign q_in = second_prime_i & MASK;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      case (cmd_i.op)
        OP_LOAD: begin
          p_q   <= p_in;
          q_q   <= q_in;
          pm1_q <= (p_in - 32'd1) & MASK;
          qm1_q <= (q_in - 32'd1) & MASK;
          pm2_q <= (p_in - 32'd2) & MASK;
        end
        OP_N: n_q <= prod;
        OP_PHI: begin
          phi_q <= prod;
          a_q   <= WIDE_W'(pub_exp_i);
          b_q   <= prod;
          m2_q  <= 64'd1;
          s2_q  <= 1'b0;
          m1_q  <= '0;
          s1_q  <= 1'b0;
        end
        OP_DIV: begin
          quo_q <= quo;
          rem_q <= rem;
        end
        OP_QM: begin
          a_q  <= b_q;
          b_q  <= rem_q;
          m2_q <= m1_q;
          s2_q <= s1_q;
          m1_q <= nm;
          s1_q <= ns;
        end
        OP_D:  d_q  <= s2_q ? (phi_q - m2_q) : m2_q;
        OP_DP: dp_q <= (pm1_q == '0) ? '0 : rem[FIELD_W-1:0];
        OP_DQ: dq_q <= (qm1_q == '0) ? '0 : rem[FIELD_W-1:0];
        OP_PWI: begin
          acc_q  <= (p_q == 32'd1) ? '0 : 32'd1;
          base_q <= rem[FIELD_W-1:0];
          ex_q   <= pm2_q;
        end
        OP_AMUL, OP_BMUL: t_q <= prod;
        OP_AMOD: acc_q <= rem[FIELD_W-1:0];
        OP_BMOD: begin
          base_q <= rem[FIELD_W-1:0];
          ex_q   <= {1'b0, ex_q[FIELD_W-1:1]};
        end
        OP_OUT: begin
          o_n_q   <= n_q;
          o_d_q   <= d_q;
          o_dp_q  <= dp_q;
          o_dq_q  <= dq_q;
          o_crt_q <= (p_q == '0) ? '0 : acc_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit && cmd_i.op == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o.unit_done = done;
    sts_o.b_zero    = (b_q == '0);
    sts_o.ex_zero   = (ex_q == '0);
    sts_o.ex_lsb    = ex_q[0];
    sts_o.out_busy  = out_valid_q && !out_ready_i;
  end

  assign out_valid_o        = out_valid_q;
  assign modulus_o          = o_n_q;
  assign decrypt_exponent_o = o_d_q;
  assign exponent_p_o       = o_dp_q;
  assign exponent_q_o       = o_dq_q;
  assign crt_coefficient_o  = o_crt_q;
endmodule
`default_nettype wire

@@ hw/rtl/rsa_crt_key_derivation.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_crt_key_derivation
// Derives n, d, dP, dQ and qInv from two primes and a public exponent.
// ----------------------------------------------------------------------------
// usage:
//   in_i carries a prime pair p, q; one transaction on out_o returns the
//   key n, d, d mod (p-1), d mod (q-1) and q^(p-2) mod p.
//   the public exponent register is written through cfg_we_i/cfg_wdata_i
//   while the block is idle, a rule on the user that the block does not
//   enforce. reset loads 65537. every product and division runs on one
//   bit-serial unit, 64 steps per operation: products for n and phi, a
//   division and a product per Euclid step on (e, phi), divisions for dP,
//   dQ and the power base, then per bit of p-2 a squaring and, for a one
//   bit, a multiply, each with its reduction. one pair is in work at a
//   time, and the controller passes through idle between pairs.
//   in_i.ready is high only while idle. a finished key sits in the output
//   register until taken; a stalled receiver holds the controller, with
//   the next key in the working registers, until the register frees.
//   reset is asynchronous, active low, and drops any transaction in work.
// ----------------------------------------------------------------------------
module rsa_crt_key_derivation #(
  parameter int unsigned PRIME_WIDTH = rsa_ckd_pkg::PRIME_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  rsa_ckd_in_if.sink       in_i,
  rsa_ckd_out_if.source    out_o
);
  import rsa_ckd_pkg::*;

  logic [FIELD_W-1:0] pub_exp_q;
  cmd_t               cmd;
  sts_t               sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pub_exp_q <= PUB_EXP_RESET;
    end else if (cfg_we_i) begin
      pub_exp_q <= cfg_wdata_i;
    end
  end

  rsa_ckd_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rsa_ckd_datapath #(
    .PRIME_WIDTH (PRIME_WIDTH)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i              (cmd),
    .sts_o              (sts),
    .first_prime_i      (in_i.first_prime),
    .second_prime_i     (in_i.second_prime),
    .pub_exp_i          (pub_exp_q),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .modulus_o          (out_o.modulus),
    .decrypt_exponent_o (out_o.decrypt_exponent),
    .exponent_p_o       (out_o.exponent_p),
    .exponent_q_o       (out_o.exponent_q),
    .crt_coefficient_o  (out_o.crt_coefficient)
  );
endmodule
`default_nettype wire

@@ hw/rtl/rsa_ckd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_ckd_checker
// Port-level checks of the key derivation block, bound to the top level.
// ----------------------------------------------------------------------------
module rsa_ckd_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i
);
  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped without a transaction");

  a_out_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_i) |-> $past(out_ready_i))
    else $error("output valid fell with ready low");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("second pair taken while one is in work");

  a_no_instant_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_i))
    else $error("key delivered right after a pair was taken");
endmodule

bind rsa_crt_key_derivation rsa_ckd_checker u_rsa_ckd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Prime pairs go in, RSA CRT keys come out; each key is checked field by field
// against a known key or an in-bench key derivation, over several public exponents.
// ----------------------------------------------------------------------------
module tb_top;
  import rsa_ckd_pkg::*;

  localparam int unsigned PW = PRIME_WIDTH_DEF;
  localparam longint unsigned CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic [63:0] modulus;
    logic [63:0] decrypt_exponent;
    logic [31:0] exponent_p;
    logic [31:0] exponent_q;
    logic [31:0] crt_coefficient;
  } rsa_key_t;

  typedef struct {
    logic [31:0] p;
    logic [31:0] q;
    bit          known;
    rsa_key_t    key;
  } pair_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  rsa_ckd_in_if  in_ch ();
  rsa_ckd_out_if out_ch ();

  rsa_crt_key_derivation #(.PRIME_WIDTH(PW)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  logic [31:0]     pub_exponent;
  rsa_key_t        pending_keys[$];
  int unsigned     mismatches;
  longint unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // x^y mod m
  function automatic logic [63:0] pow_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] b;
    if (m == 0) return 64'd0;
    acc = 64'd1 % m;
    b   = x % m;
    while (y != 0) begin
      if (y[0]) acc = (acc * b) % m;
      b = (b * b) % m;
      y = y >> 1;
    end
    return acc;
  endfunction

  function automatic rsa_key_t derive_key(logic [31:0] p_in, logic [31:0] q_in,
                                          logic [31:0] e);
    logic [63:0] msk;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] pm1;
    logic [63:0] qm1;
    logic [63:0] pm2;
    logic [63:0] phi;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] c2;
    logic [63:0] c1;
    logic [63:0] prod;
    logic [63:0] nc;
    logic [63:0] d;
    logic        s2;
    logic        s1;
    logic        ns;
    rsa_key_t    k;
    msk = (64'd1 << PW) - 64'd1;
    p   = {32'd0, p_in} & msk;
    q   = {32'd0, q_in} & msk;
    pm1 = (p - 64'd1) & msk;
    qm1 = (q - 64'd1) & msk;
    pm2 = (p - 64'd2) & msk;
    phi = pm1 * qm1;
    // extended euclid, coefficient of e kept as magnitude and sign
    a = {32'd0, e};
    b = phi;
    c2 = 64'd1; c1 = 64'd0; s2 = 1'b0; s1 = 1'b0;
    while (b > 0) begin
      quo  = a / b;
      rem  = a - quo * b;
      prod = quo * c1;
      if (prod == 0) begin
        nc = c2; ns = s2;
      end else if (s2 != s1) begin
        nc = c2 + prod; ns = s2;
      end else if (c2 >= prod) begin
        nc = c2 - prod; ns = s2;
      end else begin
        nc = prod - c2; ns = ~s2;
      end
      if (nc == 0) ns = 1'b0;
      a = b; b = rem;
      c2 = c1; s2 = s1;
      c1 = nc; s1 = ns;
    end
    d = s2 ? (phi - c2) : c2;
    k.modulus          = p * q;
    k.decrypt_exponent = d;
    k.exponent_p       = (pm1 != 0) ? 32'(d % pm1) : 32'd0;
    k.exponent_q       = (qm1 != 0) ? 32'(d % qm1) : 32'd0;
    k.crt_coefficient  = 32'(pow_mod(q, pm2, p));
    return k;
  endfunction

  task automatic send_pair(logic [31:0] p, logic [31:0] q, bit known, rsa_key_t key);
    int unsigned gap;
    gap = $urandom_range(0, 14);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.first_prime  = p;
    in_ch.second_prime = q;
    in_ch.valid        = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_keys.push_back(known ? key : derive_key(p, q, pub_exponent));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending_keys.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_exponent(logic [31:0] e);
    wait_drained();
    cfg_wdata_i = e;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    pub_exponent = e;
  endtask

  function automatic logic [31:0] draw_prime();
    case ($urandom_range(0, 9))
      0, 1:    return 32'($urandom_range(2, 255));
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'd0;
          1:       return 32'd1;
          2:       return 32'd2;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      3:       return 32'($urandom_range(256, 65535));
      default: return $urandom();
    endcase
  endfunction

  // receiver: random stall before each transaction, none while cycle_count bit 12 is set
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      stall = (cycle_count[12]) ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && rst_ni));
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    rsa_key_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_keys.size() == 0) begin
        $display("%0t: unexpected key n=%h d=%h", $time, out_ch.modulus,
                 out_ch.decrypt_exponent);
        mismatches++;
      end else begin
        want = pending_keys.pop_front();
        if (out_ch.modulus !== want.modulus) begin
          $display("%0t: modulus exp %h got %h", $time, want.modulus, out_ch.modulus);
          mismatches++;
        end
        if (out_ch.decrypt_exponent !== want.decrypt_exponent) begin
          $display("%0t: decrypt_exponent exp %h got %h", $time, want.decrypt_exponent,
                   out_ch.decrypt_exponent);
          mismatches++;
        end
        if (out_ch.exponent_p !== want.exponent_p) begin
          $display("%0t: exponent_p exp %h got %h", $time, want.exponent_p,
                   out_ch.exponent_p);
          mismatches++;
        end
        if (out_ch.exponent_q !== want.exponent_q) begin
          $display("%0t: exponent_q exp %h got %h", $time, want.exponent_q,
                   out_ch.exponent_q);
          mismatches++;
        end
        if (out_ch.crt_coefficient !== want.crt_coefficient) begin
          $display("%0t: crt_coefficient exp %h got %h", $time, want.crt_coefficient,
                   out_ch.crt_coefficient);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    pair_row_t   rows[$];
    logic [31:0] exps[$];
    rsa_key_t    none;
    int unsigned per_phase;
    mismatches   = 0;
    cycle_count  = 0;
    pub_exponent = PUB_EXP_RESET;
    none         = '0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 32'd0;
    in_ch.valid  = 1'b0;
    in_ch.first_prime  = 32'd0;
    in_ch.second_prime = 32'd0;

    // directed pairs under the reset exponent
    rows = '{
      '{32'd2, 32'd2, 1'b1, '{64'd4, 64'd0, 32'd0, 32'd0, 32'd1}},
      '{32'd1, 32'd1, 1'b1, '{64'd1, 64'd1, 32'd0, 32'd0, 32'd0}},
      '{32'd1, 32'd7, 1'b1, '{64'd7, 64'd1, 32'd0, 32'd1, 32'd0}},
      '{32'd5, 32'd1, 1'b1, '{64'd5, 64'd1, 32'd1, 32'd0, 32'd1}},
      '{32'd0, 32'd0, 1'b0, none},
      '{32'd0, 32'd3, 1'b0, none},
      '{32'd3, 32'd2, 1'b0, none},
      '{32'd3, 32'd5, 1'b0, none},
      '{32'd61, 32'd53, 1'b0, none},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, none},
      '{32'hFFFF_FFFB, 32'hFFFF_FFFF, 1'b0, none},
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, none},
      '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, none},
      '{32'hFFFF_FFFB, 32'hFFFF_FFC5, 1'b0, none}
    };
    exps = '{32'd3, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd4, $urandom(), 32'd65537};
    per_phase = (140 - rows.size()) / exps.size();

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_pair(rows[i].p, rows[i].q, rows[i].known, rows[i].key);

    foreach (exps[i]) begin
      write_exponent(exps[i]);
      for (int unsigned j = 0; j < per_phase; j++) begin
        send_pair(draw_prime(), draw_prime(), 1'b0, none);
        // sender holds off until the pipe is empty
        if (i == 2 && j == per_phase / 2) wait_drained();
      end
    end

    wait_drained();
    repeat (200) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
